// ----- design/meter_frame_receiver_defines.svh -----
// ----------------------------------------------------------------------------
// meter_frame_receiver_defines
// Assertion macros used by the checker file of the frame receiver.
// ----------------------------------------------------------------------------
`ifndef METER_FRAME_RECEIVER_DEFINES_SVH
`define METER_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, off while reset is held
`define MFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is held
`define MFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live through reset
`define MFR_ASSERT_NEXT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/mfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants of the meter frame receiver.
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam logic [7:0] START_BYTE     = 8'h68;
    localparam logic [7:0] END_BYTE       = 8'h16;
    localparam logic [7:0] DATA_OFFSET    = 8'h33;
    localparam logic [7:0] ADDR_HI_OFFSET = 8'h03;

    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX      = '1;
    localparam logic [POS_W-1:0] POS_START    = 9'd0;
    localparam logic [POS_W-1:0] POS_DELIM2   = 9'd7;
    localparam logic [POS_W-1:0] POS_CONTROL  = 9'd8;
    localparam logic [POS_W-1:0] POS_LENGTH   = 9'd9;
    localparam logic [POS_W-1:0] POS_ADDR_LO  = 9'd10;
    localparam logic [POS_W-1:0] POS_ADDR_HI  = 9'd11;
    localparam logic [POS_W-1:0] POS_DATA_LO  = 9'd15;
    localparam logic [POS_W-1:0] POS_DATA_HI  = 9'd16;
    // last payload/checksum position is this base plus the length byte
    localparam logic [POS_W-1:0] PAYLOAD_BASE = 9'd10;

    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_REFUSE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  control_code;
        logic [15:0] reg_address;
        logic [15:0] write_data;
    } t_result;

endpackage

// ----- design/mfr_if.sv -----
// ----------------------------------------------------------------------------
// mfr_byte_if / mfr_result_if
// Valid/ready channels for received bytes and decoded results.
// ----------------------------------------------------------------------------
interface mfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  control_code;
    logic [15:0] reg_address;
    logic [15:0] write_data;

    modport source (output valid, output kind, output control_code,
                    output reg_address, output write_data, input ready);
    modport sink   (input valid, input kind, input control_code,
                    input reg_address, input write_data, output ready);
endinterface

// ----- design/meter_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// meter_frame_receiver
// Byte-serial receiver for a meter frame: 68, address, 68, control,
// length, payload and checksum, 16. Reports the decoded command fields.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per transfer. o_res carries one result
//   per end-of-frame byte (kind 0, decoded fields) and one per wrong byte
//   where the end byte is due (kind 1, fields zero); other bytes give none.
//   Path: a transferred byte is registered in the input register, decoded
//   by the parser and registered in the output register to show on o_res.
//   Throughput: one byte per cycle while o_res is not stalled. The position
//   counter and field registers update once per byte taken, which sets that rate.
//   A received byte sits in an input register; the result sits in an
//   output register, so a new byte is taken while a result waits.
//   Stall: while o_res is held the held byte waits, and i_rx.ready drops
//   once the input register is full too; nothing is lost.
//   Reset (synchronous, active low): position, length and field bytes
//   clear to zero, both channel registers empty.
// ----------------------------------------------------------------------------
module meter_frame_receiver (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mfr_byte_if.sink        i_rx,
    mfr_result_if.source    o_res
);

    logic             s1_valid;
    logic [7:0]       s1_byte;
    logic             out_free;
    logic             s1_take;
    logic             res_valid;
    mfr_pkg::t_result res;

    assign s1_take = s1_valid && out_free;

    mfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (s1_take),
        .o_valid (s1_valid),
        .o_byte  (s1_byte)
    );

    mfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_take),
        .i_byte      (s1_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mfr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule

// ----- design/mfr_in_reg.sv -----
// ----------------------------------------------------------------------------
// mfr_in_reg
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module mfr_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfr_byte_if.sink    i_rx,
    input  logic        i_take,
    output logic        o_valid,
    output logic [7:0]  o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // refill in the same cycle the held byte moves on
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- design/mfr_parser.sv -----
// ----------------------------------------------------------------------------
// mfr_parser
// Frame position tracking, field capture and result decode, one byte a cycle when valid.
// ----------------------------------------------------------------------------
module mfr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output logic                o_res_valid,
    output mfr_pkg::t_result    o_res
);

    logic [mfr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0] r_len, n_len;
    logic [7:0] r_ctrl, n_ctrl;
    logic [7:0] r_addr_lo, n_addr_lo;
    logic [7:0] r_addr_hi, n_addr_hi;
    logic [7:0] r_data_lo, n_data_lo;
    logic [7:0] r_data_hi, n_data_hi;

    logic [mfr_pkg::POS_W-1:0] last_payload;
    logic [mfr_pkg::POS_W-1:0] pos_inc;
    logic hunting;
    logic in_body;
    logic is_end;
    logic keep;

    assign last_payload = mfr_pkg::PAYLOAD_BASE + {1'b0, r_len};
    assign pos_inc      = (r_pos == mfr_pkg::POS_MAX) ? r_pos : r_pos + 1'b1;
    assign hunting      = (r_pos == mfr_pkg::POS_START) || (r_pos == mfr_pkg::POS_DELIM2);
    assign in_body      = !hunting && (r_pos <= last_payload);
    assign is_end       = !hunting && !in_body && (i_byte == mfr_pkg::END_BYTE);
    // the end byte itself lands on its frame position before decode
    assign keep         = in_body || is_end;

    always_comb begin
        n_len     = r_len;
        n_ctrl    = r_ctrl;
        n_addr_lo = r_addr_lo;
        n_addr_hi = r_addr_hi;
        n_data_lo = r_data_lo;
        n_data_hi = r_data_hi;
        if (keep) begin
            unique case (r_pos)
                mfr_pkg::POS_CONTROL: n_ctrl    = i_byte;
                mfr_pkg::POS_LENGTH:  n_len     = i_byte;
                mfr_pkg::POS_ADDR_LO: n_addr_lo = i_byte;
                mfr_pkg::POS_ADDR_HI: n_addr_hi = i_byte;
                mfr_pkg::POS_DATA_LO: n_data_lo = i_byte;
                mfr_pkg::POS_DATA_HI: n_data_hi = i_byte;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (hunting) begin
            if (i_byte == mfr_pkg::START_BYTE) begin
                n_pos = pos_inc;
            end
        end else if (in_body) begin
            n_pos = pos_inc;
        end else if (is_end) begin
            n_pos = mfr_pkg::POS_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_ctrl    <= '0;
            r_addr_lo <= '0;
            r_addr_hi <= '0;
            r_data_lo <= '0;
            r_data_hi <= '0;
        end else if (i_valid) begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_ctrl    <= n_ctrl;
            r_addr_lo <= n_addr_lo;
            r_addr_hi <= n_addr_hi;
            r_data_lo <= n_data_lo;
            r_data_hi <= n_data_hi;
        end
    end

    // a byte past the payload gives a result either way; refusals carry zeros
    assign o_res_valid = i_valid && !hunting && !in_body;

    always_comb begin
        o_res = '0;
        if (is_end) begin
            o_res.kind         = mfr_pkg::KIND_FRAME;
            o_res.control_code = n_ctrl;
            o_res.reg_address  = {n_addr_hi - mfr_pkg::ADDR_HI_OFFSET,
                                  n_addr_lo - mfr_pkg::DATA_OFFSET};
            o_res.write_data   = {n_data_hi - mfr_pkg::DATA_OFFSET,
                                  n_data_lo - mfr_pkg::DATA_OFFSET};
        end else begin
            o_res.kind = mfr_pkg::KIND_REFUSE;
        end
    end

endmodule

// ----- design/mfr_out_reg.sv -----
// ----------------------------------------------------------------------------
// mfr_out_reg
// Result register: presents one decoded result until the sink takes it.
// ----------------------------------------------------------------------------
module mfr_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mfr_pkg::t_result    i_res,
    output logic                o_free,
    mfr_result_if.source        o_res
);

    logic             r_valid;
    mfr_pkg::t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.control_code = r_res.control_code;
    assign o_res.reg_address  = r_res.reg_address;
    assign o_res.write_data   = r_res.write_data;

endmodule

// ----- design/mfr_checker.sv -----
// ----------------------------------------------------------------------------
// mfr_checker
// Port-level checks of the meter frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "meter_frame_receiver_defines.svh"

module mfr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_control_code,
    input  logic [15:0] i_reg_address,
    input  logic [15:0] i_write_data
);

    // a held result stays until transferred
    `MFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")

    // refusals carry zero fields
    `MFR_ASSERT_SAME(a_refuse_zero, i_clk, i_rst_n, i_out_valid && (i_kind == mfr_pkg::KIND_REFUSE), (i_control_code == 8'd0) && (i_reg_address == 16'd0) && (i_write_data == 16'd0), "refusal with nonzero fields")

    // with no result pending the input side never stalls
    `MFR_ASSERT_SAME(a_in_ready, i_clk, i_rst_n, !i_out_valid, i_in_ready, "input stalled with empty output")

    // reset empties the output register
    `MFR_ASSERT_NEXT_RST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid, "result valid after reset")

    // with the output empty and no input transfer, the input register drains and no result follows
    `MFR_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, (!i_out_valid && !(i_in_valid && i_in_ready)) [*2], !i_out_valid, "result without a pending byte")

endmodule

bind meter_frame_receiver mfr_checker u_mfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_rx.valid),
    .i_in_ready     (i_rx.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_control_code (o_res.control_code),
    .i_reg_address  (o_res.reg_address),
    .i_write_data   (o_res.write_data)
);
